[hdl/tcgr_pkg.sv]
// Shared types, constants and codes of the text console glyph renderer.
// No dependencies; imported by the front, queue, back and top modules.
package tcgr_pkg;

  // Font geometry
  localparam int MaxGlyphRows  = 16;
  localparam int RowBits       = $clog2(MaxGlyphRows);
  localparam int MaxGlyphWidth = 8;
  localparam int GlyphCountDef = 256;
  localparam int FontIndexBits = 12;
  localparam int QueueDepth    = 4;

  // Character codes and cursor limits
  localparam logic [7:0] NewlineCode   = 8'd10;
  localparam logic [7:0] NarrowCodeMax = 8'd128;
  localparam logic [9:0] ColMax        = 10'd1023;
  localparam logic [8:0] RowMax        = 9'd511;

  // Beat kinds on the input stream (tuser)
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PUT   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FG_COLOR     = 3'd0,
    CFG_BG_COLOR     = 3'd1,
    CFG_GLYPH_WIDTH  = 3'd2,
    CFG_GLYPH_HEIGHT = 3'd3,
    CFG_PITCH        = 3'd4,
    CFG_TEXT_COLS    = 3'd5,
    CFG_TEXT_ROWS    = 3'd6,
    CFG_WIDE_FONT    = 3'd7
  } cfg_idx_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_BASE,
    BK_ROWS
  } back_state_e;

  typedef struct packed {
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic [3:0]  glyph_width;
    logic [4:0]  glyph_height;
    logic [13:0] pitch_pixels;
    logic [10:0] text_cols;
    logic [9:0]  text_rows;
    logic        wide_font;
  } cfg_t;

  // One character to draw, as queued between front and back
  typedef struct packed {
    logic [9:0] col;
    logic [8:0] row;
    logic [7:0] code;
  } job_t;

  // Glyph store write from the front
  typedef struct packed {
    logic                     en;
    logic [FontIndexBits-1:0] index;
    logic [7:0]               data;
  } font_wr_t;

  // Back-end status toward the front
  typedef struct packed {
    logic idle;
    logic clear_busy;
  } back_status_t;

endpackage

[hdl/tcgr_front.sv]
// Front end: accepts input beats, keeps the text cursor and stop flag, and
// queues draw jobs. Depends on tcgr_pkg.
module tcgr_front #(
  parameter int GLYPH_COUNT = tcgr_pkg::GlyphCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcgr_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcgr_pkg::op_e         op_i,
  input  logic [11:0]           font_index_i,
  input  logic [7:0]            font_byte_i,
  input  logic [9:0]            cursor_col_i,
  input  logic [8:0]            cursor_row_i,
  input  logic [7:0]            char_code_i,
  input  tcgr_pkg::back_status_t back_status_i,
  input  logic                  queue_full_i,
  output logic                  job_push_o,
  output tcgr_pkg::job_t        job_o,
  output tcgr_pkg::font_wr_t    font_wr_o
);
  import tcgr_pkg::*;

  logic [9:0] col_q, col_d;
  logic [8:0] row_q, row_d;
  logic       stop_q, stop_d;
  logic       accept;
  logic       draw;

  // Ready: nothing during the clear sweep; loads also wait for the back end to drain, puts need queue space
  always_comb begin
    unique case (op_i)
      OP_LOAD:  in_ready_o = !back_status_i.clear_busy && back_status_i.idle;
      OP_PUT:   in_ready_o = !back_status_i.clear_busy && !queue_full_i;
      OP_START: in_ready_o = !back_status_i.clear_busy;
      OP_NONE:  in_ready_o = !back_status_i.clear_busy;
      default:  in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  assign font_wr_o.en    = accept && (op_i == OP_LOAD);
  assign font_wr_o.index = font_index_i;
  assign font_wr_o.data  = font_byte_i;

  // Glyph is drawable: in range, not a high code on a narrow font, nonzero height
  assign draw = !(!cfg_i.wide_font && (char_code_i > NarrowCodeMax)) &&
                (32'(char_code_i) < GLYPH_COUNT) && (cfg_i.glyph_height != 5'd0);

  // Cursor update
  always_comb begin
    logic [9:0] c;
    logic [8:0] r;
    logic       hit;
    col_d      = col_q;
    row_d      = row_q;
    stop_d     = stop_q;
    job_push_o = 1'b0;
    c          = col_q;
    r          = row_q;
    hit        = 1'b0;
    job_o      = '{col: col_q, row: row_q, code: char_code_i};
    if (accept) begin
      unique case (op_i)
        OP_START: begin
          col_d  = cursor_col_i;
          row_d  = cursor_row_i;
          stop_d = 1'b0;
        end
        OP_PUT: begin
          if (stop_q) begin
            stop_d = 1'b1;
          end else if ({1'b0, row_q} >= cfg_i.text_rows) begin
            stop_d = 1'b1;
          end else if (char_code_i == NewlineCode) begin
            col_d = '0;
            if (row_q == RowMax) stop_d = 1'b1;
            else                 row_d  = row_q + 9'd1;
          end else begin
            // wrap a full line first
            if ({1'b0, col_q} >= cfg_i.text_cols) begin
              c = '0;
              if (row_q == RowMax) hit = 1'b1;
              else                 r   = row_q + 9'd1;
              if (!hit && ({1'b0, r} >= cfg_i.text_rows)) hit = 1'b1;
            end
            if (hit) begin
              stop_d = 1'b1;
              col_d  = c;
              row_d  = r;
            end else begin
              job_push_o = draw;
              job_o      = '{col: c, row: r, code: char_code_i};
              if (c == ColMax) begin
                col_d = '0;
                if (r == RowMax) begin
                  stop_d = 1'b1;
                  row_d  = r;
                end else begin
                  row_d = r + 9'd1;
                end
              end else begin
                col_d = c + 10'd1;
                row_d = r;
              end
            end
          end
        end
        OP_LOAD: ;
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      stop_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      stop_q <= stop_d;
    end
  end

endmodule

[hdl/tcgr_queue.sv]
// Short job queue between front and back end.
// Depends on tcgr_pkg for the job type.
module tcgr_queue #(
  parameter int DEPTH = tcgr_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgr_pkg::job_t data_i,
  input  logic           pop_i,
  output tcgr_pkg::job_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import tcgr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (PW+1)'(1);
        2'b01:   count_q <= count_q - (PW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/tcgr_back.sv]
// Back end: holds the glyph store and loaded flags, computes the row address
// and emits one glyph row per beat. Depends on tcgr_pkg.
module tcgr_back #(
  parameter int GLYPH_COUNT = tcgr_pkg::GlyphCountDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tcgr_pkg::cfg_t            cfg_i,
  input  tcgr_pkg::font_wr_t        font_wr_i,
  input  tcgr_pkg::job_t            job_i,
  input  logic                      job_empty_i,
  output logic                      job_pop_o,
  output tcgr_pkg::back_status_t    status_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [26:0]               row_start_o,
  output logic [tcgr_pkg::MaxGlyphWidth-1:0][31:0] pixels_o,
  output logic [3:0]                pixels_valid_o,
  output logic                      last_o
);
  import tcgr_pkg::*;

  localparam int CW    = $clog2(GLYPH_COUNT);
  localparam int AW    = CW + RowBits;
  localparam int Depth = GLYPH_COUNT * MaxGlyphRows;

  logic [7:0]    store_mem  [Depth];
  logic          loaded_mem [GLYPH_COUNT];

  back_state_e   state_q, state_d;
  job_t          job_q;
  logic [13:0]   rh_q, cw_q;
  logic          loaded_q;
  logic [26:0]   addr_q, row_addr_q;
  logic [RowBits-1:0] r_q;
  logic [7:0]    rd_q;
  logic          last_q, out_valid_q;
  logic [CW-1:0] clr_idx_q;
  logic          clr_busy_q;

  logic          adv, issue, row_last, load_ok;
  logic [3:0]    w_eff;
  logic [4:0]    h_eff;
  logic [7:0]    wr_glyph;
  logic [CW-1:0] code_idx;

  assign w_eff = (cfg_i.glyph_width > 4'(MaxGlyphWidth)) ? 4'(MaxGlyphWidth)
                                                           : cfg_i.glyph_width;
  assign h_eff = (cfg_i.glyph_height > 5'(MaxGlyphRows)) ? 5'(MaxGlyphRows)
                                                           : cfg_i.glyph_height;

  assign wr_glyph = font_wr_i.index[FontIndexBits-1:RowBits];
  assign load_ok  = font_wr_i.en && (32'(wr_glyph) < GLYPH_COUNT);
  assign code_idx = CW'(job_q.code);

  assign adv      = !out_valid_q || out_ready_i;
  assign row_last = (({1'b0, r_q} + 5'd1) == h_eff);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    issue     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_BASE;
      BK_BASE: state_d = loaded_q ? BK_ROWS : BK_IDLE;
      BK_ROWS: begin
        issue = adv;
        if (adv && row_last) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // Glyph store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (load_ok) store_mem[{CW'(wr_glyph), font_wr_i.index[RowBits-1:0]}] <= font_wr_i.data;
    if (issue)   rd_q <= store_mem[AW'({code_idx, r_q})];
  end

  // Loaded flags: cleared by a sweep after reset
  always_ff @(posedge clk_i) begin
    if (clr_busy_q)   loaded_mem[clr_idx_q] <= 1'b0;
    else if (load_ok) loaded_mem[CW'(wr_glyph)] <= 1'b1;
    if (state_q == BK_MUL) loaded_q <= loaded_mem[code_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + CW'(1);
      if (clr_idx_q == CW'(GLYPH_COUNT-1)) clr_busy_q <= 1'b0;
    end
  end

  // Address datapath: two multiply steps, then one pitch add per row
  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (state_q == BK_MUL) begin
      rh_q <= 14'({5'd0, job_q.row} * {9'd0, h_eff});
      cw_q <= 14'({4'd0, job_q.col} * {10'd0, w_eff});
    end
    if (state_q == BK_BASE) begin
      addr_q <= 27'({14'd0, rh_q} * {14'd0, cfg_i.pitch_pixels} + {14'd0, cw_q});
      r_q    <= '0;
    end
    if (issue) begin
      row_addr_q <= addr_q;
      addr_q     <= addr_q + {13'd0, cfg_i.pitch_pixels};
      last_q     <= row_last;
      r_q        <= r_q + RowBits'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (issue)       out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  // Pixel colors, leftmost pixel from bit 7
  always_comb begin
    for (int x = 0; x < MaxGlyphWidth; x++) begin
      if (4'(x) < w_eff) pixels_o[x] = rd_q[MaxGlyphWidth-1-x] ? cfg_i.fg_color
                                                                 : cfg_i.bg_color;
      else               pixels_o[x] = '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign row_start_o         = row_addr_q;
  assign pixels_valid_o      = w_eff;
  assign last_o              = last_q;
  assign status_o.idle       = (state_q == BK_IDLE) && job_empty_i;
  assign status_o.clear_busy = clr_busy_q;

endmodule

[hdl/text_console_glyph_renderer.sv]
// Top level of the text console glyph renderer: configuration registers,
// stream unpacking and the front / queue / back chain. Depends on tcgr_pkg.
//
// Input beats load font bytes (tuser 0), set the cursor (1) or put a
// character (2). A put of a drawable, loaded glyph yields one output beat
// per glyph row, tlast on the final row; newlines, wraps, skipped codes
// and unloaded glyphs only move the cursor. A load waits until all queued
// characters have been drawn. A drawn character passes address setup in
// the back end (pop, multiply and base states), then one row per cycle
// while the output is not stalled (glyph height, at most 16) through the
// single glyph store read port, overlapped with the front by a 4-entry
// job queue. After reset the block takes no input while the loaded flags
// are swept clear; configuration writes are taken throughout and must
// only be made while no character is in flight.
module text_console_glyph_renderer #(
  parameter int GLYPH_COUNT = tcgr_pkg::GlyphCountDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // font_index[11:0], font_byte[19:12], cursor_col[29:20], cursor_row[38:30],
  // char_code[46:39], zero pad[47]
  input  logic [47:0]  s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_start_pixel[26:0], pixel_0..pixel_7 at [58:27] .. [282:251],
  // pixels_valid[286:283], zero pad[287]
  output logic [287:0] m_axis_tdata,
  // last_row
  output logic         m_axis_tlast
);
  import tcgr_pkg::*;

  cfg_t         cfg_q;
  job_t         push_job, head_job;
  logic         job_push, job_pop, q_full, q_empty;
  font_wr_t     font_wr;
  back_status_t back_status;
  logic [26:0]  row_start;
  logic [MaxGlyphWidth-1:0][31:0] pixels;
  logic [3:0]   pixels_valid;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_color     <= 32'h00FF_FFFF;
      cfg_q.bg_color     <= 32'h0;
      cfg_q.glyph_width  <= 4'd8;
      cfg_q.glyph_height <= 5'd16;
      cfg_q.pitch_pixels <= 14'd1024;
      cfg_q.text_cols    <= 11'd128;
      cfg_q.text_rows    <= 10'd48;
      cfg_q.wide_font    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FG_COLOR:     cfg_q.fg_color     <= cfg_data_i;
        CFG_BG_COLOR:     cfg_q.bg_color     <= cfg_data_i;
        CFG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data_i[3:0];
        CFG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data_i[4:0];
        CFG_PITCH:        cfg_q.pitch_pixels <= cfg_data_i[13:0];
        CFG_TEXT_COLS:    cfg_q.text_cols    <= cfg_data_i[10:0];
        CFG_TEXT_ROWS:    cfg_q.text_rows    <= cfg_data_i[9:0];
        CFG_WIDE_FONT:    cfg_q.wide_font    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tcgr_front #(.GLYPH_COUNT(GLYPH_COUNT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (op_e'(s_axis_tuser)),
    .font_index_i  (s_axis_tdata[11:0]),
    .font_byte_i   (s_axis_tdata[19:12]),
    .cursor_col_i  (s_axis_tdata[29:20]),
    .cursor_row_i  (s_axis_tdata[38:30]),
    .char_code_i   (s_axis_tdata[46:39]),
    .back_status_i (back_status),
    .queue_full_i  (q_full),
    .job_push_o    (job_push),
    .job_o         (push_job),
    .font_wr_o     (font_wr)
  );

  tcgr_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (push_job),
    .pop_i   (job_pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tcgr_back #(.GLYPH_COUNT(GLYPH_COUNT)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .font_wr_i      (font_wr),
    .job_i          (head_job),
    .job_empty_i    (q_empty),
    .job_pop_o      (job_pop),
    .status_o       (back_status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .row_start_o    (row_start),
    .pixels_o       (pixels),
    .pixels_valid_o (pixels_valid),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, pixels_valid, pixels, row_start};

endmodule

[hdl/tcgr_checker.sv]
// Port-level checks of the text console glyph renderer, bound to the top.
// No package dependency; sees only the top-level ports.
module tcgr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic [2:0]   cfg_idx_i,
  input logic [31:0]  cfg_data_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [47:0]  s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // Pixel count never exceeds the glyph width limit
  a_pv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[286:283] <= 4'd8))
    else $error("pixels_valid out of range");

  // Pixel 7 reads as zero when fewer than eight pixels are valid
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[286:283] != 4'd8) |-> (m_axis_tdata[282:251] == 32'd0))
    else $error("pixel_7 set beyond pixels_valid");

  // Rows of one glyph follow each other without a gap
  a_rows_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a glyph's rows");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);
